@@ sv/lgts_pkg.sv @@
// ----------------------------------------------------------------------------
// lgts_pkg
// shared types, codes and default sizes of the lda gibbs topic sampler
// ----------------------------------------------------------------------------
`default_nettype none

package lgts_pkg;

    // default sizes
    localparam int TOPICS_DEF     = 16;
    localparam int VOCAB_DEF      = 4096;
    localparam int COUNT_BITS_DEF = 24;

    // depth of the queue between front and back, a power of two
    localparam int QUEUE_DEPTH = 2;

    // command codes
    localparam logic [2:0] CMD_WR_WORD   = 3'd0;
    localparam logic [2:0] CMD_WR_DOC    = 3'd1;
    localparam logic [2:0] CMD_WR_CORPUS = 3'd2;
    localparam logic [2:0] CMD_SAMPLE    = 3'd3;
    localparam logic [2:0] CMD_DUMP      = 3'd4;

    // result status codes
    localparam logic [1:0] STAT_WRITE_DONE = 2'd0;
    localparam logic [1:0] STAT_SAMPLE     = 2'd1;
    localparam logic [1:0] STAT_HIST       = 2'd2;
    localparam logic [1:0] STAT_ERROR      = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_NUM_TOPICS = 2'd0;
    localparam logic [1:0] REG_VOCAB_SIZE = 2'd1;
    localparam logic [1:0] REG_ALPHA_Q8   = 2'd2;
    localparam logic [1:0] REG_ETA_Q8     = 2'd3;

    // configuration reset values
    localparam logic [4:0]  RST_NUM_TOPICS = 5'd16;
    localparam logic [12:0] RST_VOCAB_SIZE = 13'd4096;
    localparam logic [15:0] RST_ALPHA_Q8   = 16'd256;
    localparam logic [15:0] RST_ETA_Q8     = 16'd26;

    typedef struct packed {
        logic [2:0]  command;
        logic [11:0] word;
        logic [3:0]  topic;
        logic [23:0] count_value;
        logic [31:0] random_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  result_topic;
        logic [23:0] result_count;
        logic        last;
    } t_out_item;

    typedef enum logic [2:0] {
        K_WR_WORD,
        K_WR_DOC,
        K_WR_CORPUS,
        K_SAMPLE,
        K_DUMP,
        K_ERROR
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [11:0] word;
        logic [3:0]  topic;
        logic [23:0] count_value;
        logic [31:0] random_value;
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RESP,
        S_DUMP,
        S_RD,
        S_PREP,
        S_MUL0,
        S_MUL1,
        S_MADD,
        S_DCHK,
        S_DIV,
        S_ACC,
        S_PROD,
        S_SRCH
    } t_state;

endpackage

`default_nettype wire

@@ sv/lgts_front.sv @@
// ----------------------------------------------------------------------------
// lgts_front
// accepts input items, checks ranges and classifies them into queue ops
// ----------------------------------------------------------------------------
`default_nettype none

module lgts_front #(
    parameter int TOPICS = lgts_pkg::TOPICS_DEF,
    parameter int VOCAB  = lgts_pkg::VOCAB_DEF,
    localparam int KW    = $clog2(TOPICS) + 1,
    localparam int VSW   = $clog2(VOCAB + 1)
) (
    input  wire                     i_valid,
    input  wire lgts_pkg::t_in_item i_item,
    output logic                    o_stall,
    input  wire  [KW-1:0]           i_k_eff,
    input  wire  [VSW-1:0]          i_vs_eff,
    input  wire                     i_full,
    output logic                    o_push,
    output lgts_pkg::t_op           o_op
);

    logic topic_bad;
    logic word_bad;

    assign topic_bad = ({{(KW > 4 ? KW - 4 : 0){1'b0}}, i_item.topic} >= i_k_eff);
    assign word_bad  = (i_item.word >= i_vs_eff);

    always_comb begin
        o_op.word         = i_item.word;
        o_op.topic        = i_item.topic;
        o_op.count_value  = i_item.count_value;
        o_op.random_value = i_item.random_value;
        case (i_item.command)
            lgts_pkg::CMD_WR_WORD: begin
                o_op.kind = (topic_bad || word_bad) ? lgts_pkg::K_ERROR : lgts_pkg::K_WR_WORD;
            end
            lgts_pkg::CMD_WR_DOC: begin
                o_op.kind = topic_bad ? lgts_pkg::K_ERROR : lgts_pkg::K_WR_DOC;
            end
            lgts_pkg::CMD_WR_CORPUS: begin
                o_op.kind = topic_bad ? lgts_pkg::K_ERROR : lgts_pkg::K_WR_CORPUS;
            end
            lgts_pkg::CMD_SAMPLE: begin
                o_op.kind = (topic_bad || word_bad) ? lgts_pkg::K_ERROR : lgts_pkg::K_SAMPLE;
            end
            lgts_pkg::CMD_DUMP: begin
                o_op.kind = lgts_pkg::K_DUMP;
            end
            default: begin
                o_op.kind = lgts_pkg::K_ERROR;
            end
        endcase
    end

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

endmodule

`default_nettype wire

@@ sv/lgts_fifo.sv @@
// ----------------------------------------------------------------------------
// lgts_fifo
// short queue of classified ops between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module lgts_fifo (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  wire lgts_pkg::t_op i_op,
    output logic               o_full,
    input  wire                i_pop,
    output logic               o_empty,
    output lgts_pkg::t_op      o_head
);

    localparam int QA = $clog2(lgts_pkg::QUEUE_DEPTH);

    lgts_pkg::t_op r_buf [lgts_pkg::QUEUE_DEPTH];
    logic [QA-1:0] r_wp, n_wp;
    logic [QA-1:0] r_rp, n_rp;
    logic [QA:0]   r_cnt, n_cnt;

    assign o_full  = (r_cnt == (QA + 1)'(lgts_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_buf[r_rp];

    always_comb begin
        n_wp  = i_push ? r_wp + 1'b1 : r_wp;
        n_rp  = i_pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_op;
        end
    end

endmodule

`default_nettype wire

@@ sv/lgts_back.sv @@
// ----------------------------------------------------------------------------
// lgts_back
// carries out queued ops: table writes, topic sampling and histogram dump
// ----------------------------------------------------------------------------
`default_nettype none

module lgts_back #(
    parameter int TOPICS     = lgts_pkg::TOPICS_DEF,
    parameter int VOCAB      = lgts_pkg::VOCAB_DEF,
    parameter int COUNT_BITS = lgts_pkg::COUNT_BITS_DEF,
    localparam int KW        = $clog2(TOPICS) + 1
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire  [KW-1:0]            i_k_eff,
    input  wire  [15:0]              i_alpha,
    input  wire  [15:0]              i_eta,
    input  wire                      i_empty,
    input  wire lgts_pkg::t_op       i_head,
    output logic                     o_pop,
    input  wire                      i_stall,
    output logic                     o_valid,
    output lgts_pkg::t_out_item      o_item
);

    localparam int TB   = $clog2(TOPICS);
    localparam int WB   = $clog2(VOCAB);
    localparam int CB   = COUNT_BITS;
    localparam int LW   = CB + 9;
    localparam int PW   = 2 * LW;
    localparam int DW   = ((CB + 8 > TB + 17) ? CB + 8 : TB + 17) + 1;
    localparam int GLO  = LW / 2;
    localparam int GHI  = LW - GLO;
    localparam int MD   = 1 << (WB + TB);

    localparam logic [CB-1:0] CNT_MAX = {CB{1'b1}};

    // storage
    logic [CB-1:0] r_mem [MD];
    logic [CB-1:0] r_rdata;
    logic [CB-1:0] r_doc [TOPICS];
    logic [CB-1:0] r_corp [TOPICS];
    logic [CB-1:0] r_hist [TOPICS];
    logic [31:0]   r_sum [TOPICS];

    // control
    lgts_pkg::t_state r_state, n_state;
    lgts_pkg::t_op    r_op;
    logic [TB-1:0]    r_j;
    logic [4:0]       r_bit;
    logic [1:0]       r_resp_stat;
    logic [3:0]       r_resp_topic;
    logic [TB-1:0]    r_pick;
    logic             r_hist_inc;
    logic             r_out_valid;
    lgts_pkg::t_out_item r_out;

    // datapath
    logic [LW-1:0]     r_l, r_g;
    logic [DW-1:0]     r_d;
    logic [LW+GLO-1:0] r_pp0;
    logic [LW+GHI-1:0] r_pp1;
    logic [PW-1:0]     r_prod;
    logic [DW-1:0]     r_rem;
    logic [31:0]       r_low;
    logic [31:0]       r_q;
    logic [31:0]       r_total;
    logic [63:0]       r_rt;

    logic [TB-1:0]       k_last;
    logic                out_free;
    logic                out_load;
    lgts_pkg::t_out_item out_item;
    logic                mem_we;
    logic [WB+TB-1:0]    mem_waddr;
    logic [WB+TB-1:0]    mem_raddr;
    logic                own_topic;
    logic [CB-1:0]       g_cnt, l_cnt;
    logic                d_zero;
    logic                d_sat;
    logic [DW:0]         rem2;
    logic                q_bit;
    logic [32:0]         acc;
    logic                hit;

    assign k_last   = TB'(i_k_eff - 1'b1);
    assign out_free = !r_out_valid || !i_stall;
    assign o_valid  = r_out_valid;
    assign o_item   = r_out;

    assign mem_waddr = {WB'(i_head.word), TB'(i_head.topic)};
    assign mem_raddr = {WB'(r_op.word), r_j};

    // own count removed on the current topic, clamped at zero
    assign own_topic = (r_j == TB'(r_op.topic));
    assign g_cnt = (own_topic && r_rdata != '0) ? r_rdata - 1'b1 : r_rdata;
    assign l_cnt = (own_topic && r_doc[r_j] != '0) ? r_doc[r_j] - 1'b1 : r_doc[r_j];

    assign d_zero = (r_d == '0);
    assign d_sat  = (r_prod[PW-1:32] >= r_d);

    assign rem2  = {r_rem, r_low[31]};
    assign q_bit = (rem2 >= {1'b0, r_d});

    assign acc = {1'b0, r_total} + {1'b0, r_q};
    assign hit = (r_rt[63:32] < r_sum[r_j]);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lgts_pkg::S_IDLE: begin
                if (!i_empty) begin
                    case (i_head.kind)
                        lgts_pkg::K_SAMPLE: n_state = lgts_pkg::S_RD;
                        lgts_pkg::K_DUMP:   n_state = lgts_pkg::S_DUMP;
                        default:            n_state = lgts_pkg::S_RESP;
                    endcase
                end
            end
            lgts_pkg::S_RESP: begin
                if (out_free) n_state = lgts_pkg::S_IDLE;
            end
            lgts_pkg::S_DUMP: begin
                if (out_free && r_j == k_last) n_state = lgts_pkg::S_IDLE;
            end
            lgts_pkg::S_RD:   n_state = lgts_pkg::S_PREP;
            lgts_pkg::S_PREP: n_state = lgts_pkg::S_MUL0;
            lgts_pkg::S_MUL0: n_state = lgts_pkg::S_MUL1;
            lgts_pkg::S_MUL1: n_state = lgts_pkg::S_MADD;
            lgts_pkg::S_MADD: n_state = lgts_pkg::S_DCHK;
            lgts_pkg::S_DCHK: begin
                n_state = (d_zero || d_sat) ? lgts_pkg::S_ACC : lgts_pkg::S_DIV;
            end
            lgts_pkg::S_DIV: begin
                if (r_bit == '0) n_state = lgts_pkg::S_ACC;
            end
            lgts_pkg::S_ACC: begin
                n_state = (r_j == k_last) ? lgts_pkg::S_PROD : lgts_pkg::S_RD;
            end
            lgts_pkg::S_PROD: n_state = lgts_pkg::S_SRCH;
            lgts_pkg::S_SRCH: begin
                if (r_j == k_last || hit) n_state = lgts_pkg::S_RESP;
            end
            default: n_state = lgts_pkg::S_IDLE;
        endcase
    end

    // handshake and result outputs
    always_comb begin
        o_pop    = 1'b0;
        mem_we   = 1'b0;
        out_load = 1'b0;
        out_item.status       = r_resp_stat;
        out_item.result_topic = r_resp_topic;
        out_item.result_count = '0;
        out_item.last         = 1'b1;
        case (r_state)
            lgts_pkg::S_IDLE: begin
                o_pop  = !i_empty;
                mem_we = !i_empty && (i_head.kind == lgts_pkg::K_WR_WORD);
            end
            lgts_pkg::S_RESP: begin
                out_load = out_free;
            end
            lgts_pkg::S_DUMP: begin
                out_load = out_free;
                out_item.status       = lgts_pkg::STAT_HIST;
                out_item.result_topic = 4'(r_j);
                out_item.result_count = 24'(r_hist[r_j]);
                out_item.last         = (r_j == k_last);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lgts_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= out_item;
        end
    end

    // word-topic table
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= CB'(i_head.count_value);
        end
        r_rdata <= r_mem[mem_raddr];
    end

    // histogram, cleared at reset and after a dump
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TOPICS; i++) r_hist[i] <= '0;
        end else if (r_state == lgts_pkg::S_DUMP && out_free && r_j == k_last) begin
            for (int i = 0; i < TOPICS; i++) r_hist[i] <= '0;
        end else if (r_state == lgts_pkg::S_RESP && out_free && r_hist_inc) begin
            if (r_hist[r_pick] != CNT_MAX) r_hist[r_pick] <= r_hist[r_pick] + 1'b1;
        end
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            lgts_pkg::S_IDLE: begin
                if (!i_empty) begin
                    r_op         <= i_head;
                    r_j          <= '0;
                    r_total      <= '0;
                    r_resp_topic <= '0;
                    r_hist_inc   <= 1'b0;
                    r_resp_stat  <= (i_head.kind == lgts_pkg::K_ERROR) ?
                                    lgts_pkg::STAT_ERROR : lgts_pkg::STAT_WRITE_DONE;
                    if (i_head.kind == lgts_pkg::K_WR_DOC) begin
                        r_doc[TB'(i_head.topic)] <= CB'(i_head.count_value);
                    end
                    if (i_head.kind == lgts_pkg::K_WR_CORPUS) begin
                        r_corp[TB'(i_head.topic)] <= CB'(i_head.count_value);
                    end
                end
            end
            lgts_pkg::S_DUMP: begin
                if (out_free) r_j <= r_j + 1'b1;
            end
            lgts_pkg::S_PREP: begin
                r_l <= LW'({l_cnt, 8'h00}) + LW'(i_alpha);
                r_g <= LW'({g_cnt, 8'h00}) + LW'(i_eta);
                r_d <= DW'({r_corp[r_j], 8'h00}) + DW'(i_k_eff) * DW'(i_eta);
            end
            lgts_pkg::S_MUL0: begin
                r_pp0 <= r_l * r_g[GLO-1:0];
            end
            lgts_pkg::S_MUL1: begin
                r_pp1 <= r_l * r_g[LW-1:GLO];
            end
            lgts_pkg::S_MADD: begin
                r_prod <= PW'(r_pp0) + (PW'(r_pp1) << GLO);
            end
            lgts_pkg::S_DCHK: begin
                // zero denominator gives zero, a quotient past 32 bits saturates
                r_q   <= d_zero ? 32'd0 : (d_sat ? 32'hFFFF_FFFF : 32'd0);
                r_rem <= DW'(r_prod[PW-1:32]);
                r_low <= r_prod[31:0];
                r_bit <= 5'd31;
            end
            lgts_pkg::S_DIV: begin
                r_rem <= q_bit ? DW'(rem2 - {1'b0, r_d}) : DW'(rem2);
                r_low <= {r_low[30:0], 1'b0};
                r_q   <= {r_q[30:0], q_bit};
                r_bit <= r_bit - 1'b1;
            end
            lgts_pkg::S_ACC: begin
                r_total  <= acc[32] ? 32'hFFFF_FFFF : acc[31:0];
                r_sum[r_j] <= acc[32] ? 32'hFFFF_FFFF : acc[31:0];
                if (r_j != k_last) r_j <= r_j + 1'b1;
            end
            lgts_pkg::S_PROD: begin
                r_rt <= r_op.random_value * r_total;
                r_j  <= '0;
            end
            lgts_pkg::S_SRCH: begin
                if (r_j == k_last || hit) begin
                    r_pick       <= r_j;
                    r_resp_topic <= 4'(r_j);
                    r_resp_stat  <= lgts_pkg::STAT_SAMPLE;
                    r_hist_inc   <= 1'b1;
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/lda_gibbs_topic_sampler_unit.sv @@
// ----------------------------------------------------------------------------
// lda_gibbs_topic_sampler_unit
// collapsed gibbs topic sampler for lda with loadable count tables
// ----------------------------------------------------------------------------
// Items enter through a front stage that range-checks and classifies them
// into a two-entry queue; a back sequencer carries them out one at a time
// and drives a registered result port. A dump gives K results, one per
// cycle while the result port is not stalled. A sample walks the K topics
// in use through one shared datapath: table read, operand build, two partial
// products, a sum, and a restoring divider that retires one quotient bit per
// cycle; the divider is skipped when the denominator is zero or the quotient
// saturates. After the last topic it forms r*total, searches the topics for
// the pick and loads the result. The word-topic table is a memory of
// 2^clog2(VOCAB)*2^clog2(TOPICS) entries with one write port and a
// registered read port; it needs no clearing pass only if every entry is
// written before it is read, which the user must ensure, as the block itself
// does not enforce it. The histogram is reset to zero and cleared after a
// dump. Configuration is to be written over the apb port only while the block
// is idle; the user must keep to this, the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module lda_gibbs_topic_sampler_unit #(
    parameter int TOPICS     = lgts_pkg::TOPICS_DEF,
    parameter int VOCAB      = lgts_pkg::VOCAB_DEF,
    parameter int COUNT_BITS = lgts_pkg::COUNT_BITS_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    // input item channel
    input  wire                      i_in_valid,
    input  wire lgts_pkg::t_in_item  i_in_item,
    output logic                     o_in_stall,
    // result item channel
    output logic                     o_out_valid,
    output lgts_pkg::t_out_item      o_out_item,
    input  wire                      i_out_stall,
    // apb configuration port
    input  wire                      psel,
    input  wire                      penable,
    input  wire                      pwrite,
    input  wire  [3:0]               paddr,
    input  wire  [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int KW  = $clog2(TOPICS) + 1;
    localparam int VSW = $clog2(VOCAB + 1);

    // configuration registers
    logic [4:0]  r_num_topics;
    logic [12:0] r_vocab_size;
    logic [15:0] r_alpha_q8;
    logic [15:0] r_eta_q8;

    logic          cfg_wr;
    logic [KW-1:0] k_eff;
    logic [VSW-1:0] vs_eff;

    logic          push;
    lgts_pkg::t_op push_op;
    logic          full;
    logic          pop;
    logic          empty;
    lgts_pkg::t_op head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_topics <= lgts_pkg::RST_NUM_TOPICS;
            r_vocab_size <= lgts_pkg::RST_VOCAB_SIZE;
            r_alpha_q8   <= lgts_pkg::RST_ALPHA_Q8;
            r_eta_q8     <= lgts_pkg::RST_ETA_Q8;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                lgts_pkg::REG_NUM_TOPICS: r_num_topics <= pwdata[4:0];
                lgts_pkg::REG_VOCAB_SIZE: r_vocab_size <= pwdata[12:0];
                lgts_pkg::REG_ALPHA_Q8:   r_alpha_q8   <= pwdata[15:0];
                lgts_pkg::REG_ETA_Q8:     r_eta_q8     <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        case (paddr[3:2])
            lgts_pkg::REG_NUM_TOPICS: prdata = {27'd0, r_num_topics};
            lgts_pkg::REG_VOCAB_SIZE: prdata = {19'd0, r_vocab_size};
            lgts_pkg::REG_ALPHA_Q8:   prdata = {16'd0, r_alpha_q8};
            lgts_pkg::REG_ETA_Q8:     prdata = {16'd0, r_eta_q8};
            default:                  prdata = '0;
        endcase
    end

    // topic count saturated into 1..TOPICS
    always_comb begin
        if (r_num_topics == '0) begin
            k_eff = KW'(1);
        end else if (r_num_topics > TOPICS) begin
            k_eff = KW'(TOPICS);
        end else begin
            k_eff = KW'(r_num_topics);
        end
    end

    // vocabulary size saturated into 1..VOCAB
    always_comb begin
        if (r_vocab_size == '0) begin
            vs_eff = VSW'(1);
        end else if (r_vocab_size > VOCAB) begin
            vs_eff = VSW'(VOCAB);
        end else begin
            vs_eff = VSW'(r_vocab_size);
        end
    end

    lgts_front #(
        .TOPICS (TOPICS),
        .VOCAB  (VOCAB)
    ) u_front (
        .i_valid  (i_in_valid),
        .i_item   (i_in_item),
        .o_stall  (o_in_stall),
        .i_k_eff  (k_eff),
        .i_vs_eff (vs_eff),
        .i_full   (full),
        .o_push   (push),
        .o_op     (push_op)
    );

    lgts_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (head)
    );

    lgts_back #(
        .TOPICS     (TOPICS),
        .VOCAB      (VOCAB),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_k_eff (k_eff),
        .i_alpha (r_alpha_q8),
        .i_eta   (r_eta_q8),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_item  (o_out_item)
    );

endmodule

`default_nettype wire
